>>> rtl/lcnc_pkg.sv
// ----------------------------------------------------------------------------
// lcnc_pkg: shared types and helpers for the Luhn card number check
// Widths, the word that travels down the conversion chain, brand codes.
// ----------------------------------------------------------------------------
package lcnc_pkg;

  localparam int unsigned CARD_W     = 63;
  localparam int unsigned NUM_DIGITS = 19;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned MAX_DIGITS = 19;
  localparam int unsigned HALF_W     = 7;
  localparam int unsigned SUM_W      = 8;

  typedef enum logic [1:0] {
    BRAND_NONE = 2'd0,
    BRAND_AMEX = 2'd1,
    BRAND_MC   = 2'd2,
    BRAND_VISA = 2'd3
  } brand_e;

  // One word in flight through the binary-to-decimal chain.
  typedef struct packed {
    logic              vld;
    logic [CARD_W-1:0] bin;
    logic [BCD_W-1:0]  bcd;
  } word_t;

  // Luhn contribution of a digit in a doubled position.
  function automatic logic [3:0] luhn_double(input logic [3:0] d);
    logic [4:0] dd;
    begin
      dd = {d, 1'b0};
      if (d >= 4'd5) begin
        dd = dd - 5'd9;
      end
      return dd[3:0];
    end
  endfunction

  // True when the sum is a multiple of ten.
  function automatic logic is_mult10(input logic [SUM_W-1:0] s);
    logic hit;
    begin
      hit = 1'b0;
      for (int k = 0; k * 10 < (1 << SUM_W); k++) begin
        if (s == SUM_W'(k * 10)) begin
          hit = 1'b1;
        end
      end
      return hit;
    end
  endfunction

endpackage

>>> rtl/lcnc_cell.sv
// ----------------------------------------------------------------------------
// lcnc_cell: one shift-and-add-3 step of the binary-to-decimal chain
// Adjusts every decimal digit that is 5 or more, then shifts the next binary
// bit into the decimal digits, and hands the word to the next cell.
// ----------------------------------------------------------------------------
module lcnc_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  lcnc_pkg::word_t word_i,
  output lcnc_pkg::word_t word_o
);

  logic [lcnc_pkg::BCD_W-1:0]  bcd_adj;
  logic [lcnc_pkg::BCD_W-1:0]  bcd_d;
  logic [lcnc_pkg::CARD_W-1:0] bin_d;
  logic                        vld_q;
  logic [lcnc_pkg::BCD_W-1:0]  bcd_q;
  logic [lcnc_pkg::CARD_W-1:0] bin_q;

  always_comb begin
    for (int i = 0; i < lcnc_pkg::NUM_DIGITS; i++) begin
      if (word_i.bcd[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = word_i.bcd[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = word_i.bcd[4*i +: 4];
      end
    end
    bcd_d = {bcd_adj[lcnc_pkg::BCD_W-2:0], word_i.bin[lcnc_pkg::CARD_W-1]};
    bin_d = {word_i.bin[lcnc_pkg::CARD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= word_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    bcd_q <= bcd_d;
    bin_q <= bin_d;
  end

  assign word_o = '{vld: vld_q, bin: bin_q, bcd: bcd_q};

endmodule

>>> rtl/lcnc_classify.sv
// ----------------------------------------------------------------------------
// lcnc_classify: Luhn sum, digit count and brand from the decimal digits
// Two stages: partial Luhn sums, count and prefix match; then the total,
// the mod-10 test and the final brand.
// ----------------------------------------------------------------------------
module lcnc_classify (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lcnc_pkg::word_t               word_i,
  output logic                          result_valid_o,
  output logic [1:0]                    brand_o,
  output logic                          luhn_ok_o,
  output logic [lcnc_pkg::COUNT_W-1:0]  digit_count_o
);

  logic [3:0]                   dig [lcnc_pkg::NUM_DIGITS];
  logic [lcnc_pkg::HALF_W-1:0]  s_odd_d, s_even_d;
  logic [lcnc_pkg::COUNT_W-1:0] cnt_d;
  lcnc_pkg::brand_e             cand_d;
  logic                         len_ok_d;

  logic                         vld1_q;
  logic [lcnc_pkg::HALF_W-1:0]  s_odd_q, s_even_q;
  logic [lcnc_pkg::COUNT_W-1:0] cnt_q;
  lcnc_pkg::brand_e             cand_q;
  logic                         len_ok_q;

  logic [lcnc_pkg::SUM_W-1:0]   sum;
  logic                         luhn_d;
  lcnc_pkg::brand_e             brand_d;

  logic                         vld2_q;
  logic                         luhn_q;
  lcnc_pkg::brand_e             brand_q;
  logic [lcnc_pkg::COUNT_W-1:0] cnt2_q;

  // Stage 1.
  always_comb begin
    for (int i = 0; i < lcnc_pkg::NUM_DIGITS; i++) begin
      dig[i] = word_i.bcd[4*i +: 4];
    end
    s_odd_d  = '0;
    s_even_d = '0;
    cnt_d    = '0;
    for (int i = 0; i < lcnc_pkg::NUM_DIGITS; i++) begin
      if ((i % 2) == 0) begin
        s_odd_d = s_odd_d + lcnc_pkg::HALF_W'(dig[i]);
      end else begin
        s_even_d = s_even_d + lcnc_pkg::HALF_W'(lcnc_pkg::luhn_double(dig[i]));
      end
      if (dig[i] != 4'd0) begin
        cnt_d = lcnc_pkg::COUNT_W'(i + 1);
      end
    end
    if (cnt_d > lcnc_pkg::COUNT_W'(lcnc_pkg::MAX_DIGITS)) begin
      cnt_d = lcnc_pkg::COUNT_W'(lcnc_pkg::MAX_DIGITS);
    end
    len_ok_d = (cnt_d == 5'd13) || (cnt_d == 5'd15) || (cnt_d == 5'd16);

    // With the length known, each brand range reduces to its leading digits.
    priority if (cnt_d == 5'd15 && dig[14] == 4'd3 &&
                 (dig[13] == 4'd4 || dig[13] == 4'd7)) begin
      cand_d = lcnc_pkg::BRAND_AMEX;
    end else if (cnt_d == 5'd16 && dig[15] == 4'd5 &&
                 dig[14] >= 4'd1 && dig[14] <= 4'd5) begin
      cand_d = lcnc_pkg::BRAND_MC;
    end else if ((cnt_d == 5'd16 && dig[15] == 4'd4) ||
                 (cnt_d == 5'd13 && dig[12] == 4'd4)) begin
      cand_d = lcnc_pkg::BRAND_VISA;
    end else begin
      cand_d = lcnc_pkg::BRAND_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= word_i.vld;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s_odd_q  <= s_odd_d;
    s_even_q <= s_even_d;
    cnt_q    <= cnt_d;
    cand_q   <= cand_d;
    len_ok_q <= len_ok_d;
  end

  // Stage 2.
  always_comb begin
    sum    = lcnc_pkg::SUM_W'(s_odd_q) + lcnc_pkg::SUM_W'(s_even_q);
    luhn_d = lcnc_pkg::is_mult10(sum);
    if (len_ok_q && luhn_d) begin
      brand_d = cand_q;
    end else begin
      brand_d = lcnc_pkg::BRAND_NONE;
    end
  end

  always_ff @(posedge clk_i) begin
    luhn_q  <= luhn_d;
    brand_q <= brand_d;
    cnt2_q  <= cnt_q;
  end

  assign result_valid_o = vld2_q;
  assign brand_o        = brand_q;
  assign luhn_ok_o      = luhn_q;
  assign digit_count_o  = cnt2_q;

endmodule

>>> rtl/luhn_card_number_check.sv
// ----------------------------------------------------------------------------
// luhn_card_number_check: Luhn mod-10 check and brand of a card number
//
//   channel  direction  handshake                  word
//   command  in         start / busy               card_number_i
//   result   out        result_valid_o (1 cycle)   brand_o, luhn_ok_o,
//                                                  digit_count_o
//
// A new word is taken in every cycle; busy stays low. Each word passes a
// chain of 63 shift-and-add-3 cells (one per input bit) and then two
// classify stages. Reset clears only the valid bits of the chain and of
// the classify stages. The receiver cannot stall the results.
// ----------------------------------------------------------------------------
module luhn_card_number_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [lcnc_pkg::CARD_W-1:0]   card_number_i,
  output logic                          result_valid_o,
  output logic [1:0]                    brand_o,
  output logic                          luhn_ok_o,
  output logic [lcnc_pkg::COUNT_W-1:0]  digit_count_o
);

  lcnc_pkg::word_t chain [lcnc_pkg::CARD_W + 1];

  assign busy     = 1'b0;
  assign chain[0] = '{vld: start && !busy, bin: card_number_i, bcd: '0};

  for (genvar k = 0; k < lcnc_pkg::CARD_W; k++) begin : g_cell
    lcnc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .word_i (chain[k]),
      .word_o (chain[k+1])
    );
  end

  lcnc_classify u_classify (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .word_i         (chain[lcnc_pkg::CARD_W]),
    .result_valid_o (result_valid_o),
    .brand_o        (brand_o),
    .luhn_ok_o      (luhn_ok_o),
    .digit_count_o  (digit_count_o)
  );

endmodule
